[src/wavhv_pkg.sv]
// ----------------------------------------------------------------------------
// wavhv_pkg
// Tags, status codes and shared types for the WAV header validator.
// ----------------------------------------------------------------------------
package wavhv_pkg;

   localparam logic [31:0] TAG_RIFF = 32'h52494646;
   localparam logic [31:0] TAG_WAVE = 32'h57415645;
   localparam logic [31:0] TAG_FMT  = 32'h666d7420;
   localparam logic [31:0] TAG_DATA = 32'h64617461;

   localparam logic [31:0] HDR_START   = 32'd12;
   localparam logic [31:0] FMT_MIN_LEN = 32'd16;
   localparam logic [31:0] RATE_48K    = 32'd48000;
   localparam logic [31:0] RATE_44K    = 32'd44100;
   localparam logic [15:0] FMT_PCM     = 16'h0001;
   localparam logic [15:0] BITS_16     = 16'd16;
   localparam logic [15:0] MONO        = 16'd1;

   localparam int RSP_DATA_W = 88;

   typedef enum logic [4:0] {
      ST_OK         = 5'd0,
      ST_TOO_LONG   = 5'd1,
      ST_SHORT      = 5'd2,
      ST_NOT_RIFF   = 5'd3,
      ST_NOT_WAVE   = 5'd4,
      ST_BAD_SIZE   = 5'd5,
      ST_BAD_WALK   = 5'd6,
      ST_TWO_FMT    = 5'd7,
      ST_TWO_DATA   = 5'd8,
      ST_NO_FMT     = 5'd9,
      ST_NO_DATA    = 5'd10,
      ST_FMT_SHORT  = 5'd11,
      ST_COMPRESSED = 5'd12,
      ST_NOT_16BIT  = 5'd13,
      ST_NOT_MONO   = 5'd14,
      ST_BAD_RATE   = 5'd15,
      ST_ODD_DATA   = 5'd16
   } status_type;

   typedef enum logic [1:0] {
      WALK_NONE     = 2'd0,
      WALK_FAIL     = 2'd1,
      WALK_TWO_FMT  = 2'd2,
      WALK_TWO_DATA = 2'd3
   } walk_err_type;

   typedef struct packed {
      logic [31:0]  len;
      logic         riff_ok;
      logic         wave_ok;
      logic [31:0]  riff_size;
      walk_err_type walk_err;
      logic         walk_done;
      logic         fmt_found;
      logic         data_found;
      logic         fmt_short;
      logic [15:0]  fmt_tag;
      logic [15:0]  channels;
      logic [31:0]  rate;
      logic [15:0]  bits;
      logic [31:0]  data_start;
      logic [31:0]  data_length;
   } snap_type;

endpackage

[src/wav_header_validator_core.sv]
// ----------------------------------------------------------------------------
// wav_header_validator_core
// Parses a RIFF/WAVE byte stream and reports one status beat per file.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                                   tuser / tlast
//  req      in   data_byte[7:0]                          tlast = last_byte
//  rsp      out  status, data_offset, count, rate        none
//
//  One byte accepted per cycle while the result path is not backed up;
//  the byte register feeds the header state update, which is combinational
//  into the state registers. The result beat then passes through the
//  snapshot and response registers. A held result stalls input only once
//  a second finished file waits behind it. Reset is synchronous.
// ----------------------------------------------------------------------------
module wav_header_validator_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // data_byte[7:0]
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // status[4:0], data_offset[35:5], sample_count[65:36], sample_rate[81:66]
   output logic [wavhv_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;

   logic [31:0] count_ff, count_in;
   logic [31:0] riff_tag_ff, riff_tag_in;
   logic [31:0] riff_size_ff, riff_size_in;
   logic [31:0] wave_tag_ff, wave_tag_in;
   logic [31:0] ncp_ff, ncp_in;
   logic [31:0] chunk_type_ff, chunk_type_in;
   logic [31:0] chunk_size_ff, chunk_size_in;
   logic        walk_done_ff, walk_done_in;
   wavhv_pkg::walk_err_type walk_err_ff, walk_err_in;
   logic        fmt_found_ff, fmt_found_in;
   logic [31:0] fmt_start_ff, fmt_start_in;
   logic [31:0] fmt_length_ff, fmt_length_in;
   logic [15:0][7:0] fmt_fields_ff, fmt_fields_in;
   logic        data_found_ff, data_found_in;
   logic [31:0] data_start_ff, data_start_in;
   logic [31:0] data_length_ff, data_length_in;

   logic                 snap_valid_ff;
   wavhv_pkg::snap_type  snap_ff, snap_in;

   logic                            rsp_valid_ff;
   logic [wavhv_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic out_ready, snap_ready, proc_ready, proc_fire;

   function automatic logic [1:0] walk_check(input logic [31:0] pos,
                                             input logic [31:0] size);
      logic signed [33:0] pos_s;
      logic signed [33:0] size_s;
      logic               done;
      logic               fail;
      pos_s  = $signed({2'b00, pos});
      size_s = $signed({{2{size[31]}}, size});
      done   = pos_s >= size_s + 34'sd8;
      fail   = !done && (pos_s > size_s);
      return {done, fail};
   endfunction

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign snap_ready = !snap_valid_ff || out_ready;
   assign proc_ready = !in_valid_ff || snap_ready;
   assign proc_fire  = in_valid_ff && proc_ready;
   assign req_tready = proc_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   always_comb begin
      logic [31:0]        p;
      logic [7:0]         b;
      logic [32:0]        hdr_diff;
      logic [32:0]        fmt_diff;
      logic               hdr_hit;
      logic               fmt_hit;
      logic [2:0]         off;
      logic [31:0]        ckl;
      logic signed [33:0] room;
      logic [31:0]        ncp_new;
      logic [1:0]         wchk;

      p        = count_ff;
      b        = in_byte_ff;
      hdr_diff = {1'b0, count_ff} - {1'b0, ncp_ff};
      fmt_diff = {1'b0, count_ff} - {1'b0, fmt_start_ff};
      off      = hdr_diff[2:0];
      hdr_hit  = !(count_ff[31:4] == 28'd0 && count_ff[3:2] != 2'b11) &&
                 !walk_done_ff && (walk_err_ff == wavhv_pkg::WALK_NONE) &&
                 !hdr_diff[32] && (hdr_diff[31:3] == 30'd0);
      fmt_hit  = fmt_found_ff && !fmt_diff[32] && (fmt_diff[31:4] == 29'd0);
      ckl      = {b, chunk_size_ff[23:0]};
      room     = $signed({{2{riff_size_ff[31]}}, riff_size_ff}) - $signed({2'b00, ncp_ff});
      ncp_new  = ncp_ff + 32'd8 + ckl + {31'd0, ckl[0]};
      wchk     = 2'b00;

      count_in       = count_ff;
      riff_tag_in    = riff_tag_ff;
      riff_size_in   = riff_size_ff;
      wave_tag_in    = wave_tag_ff;
      ncp_in         = ncp_ff;
      chunk_type_in  = chunk_type_ff;
      chunk_size_in  = chunk_size_ff;
      walk_done_in   = walk_done_ff;
      walk_err_in    = walk_err_ff;
      fmt_found_in   = fmt_found_ff;
      fmt_start_in   = fmt_start_ff;
      fmt_length_in  = fmt_length_ff;
      fmt_fields_in  = fmt_fields_ff;
      data_found_in  = data_found_ff;
      data_start_in  = data_start_ff;
      data_length_in = data_length_ff;

      if (proc_fire && !p[31]) begin
         if (p[31:2] == 30'd0) begin
            riff_tag_in = {riff_tag_ff[23:0], b};
         end else if (p[31:3] == 29'd0) begin
            riff_size_in[{p[1:0], 3'b000} +: 8] = b;
         end else if (p[31:4] == 28'd0 && p[3:2] == 2'b10) begin
            wave_tag_in = {wave_tag_ff[23:0], b};
         end

         if (p == 32'd7) begin
            wchk = walk_check(wavhv_pkg::HDR_START, riff_size_in);
            walk_done_in = wchk[1];
            if (wchk[0]) begin
               walk_err_in = wavhv_pkg::WALK_FAIL;
            end
         end else if (hdr_hit) begin
            if (!off[2]) begin
               chunk_type_in = {chunk_type_ff[23:0], b};
            end else begin
               chunk_size_in[{off[1:0], 3'b000} +: 8] = b;
            end
            if (off == 3'd7) begin
               if (ckl[31] || ($signed({2'b00, ckl}) > room)) begin
                  walk_err_in = wavhv_pkg::WALK_FAIL;
               end else if (chunk_type_ff == wavhv_pkg::TAG_FMT && fmt_found_ff) begin
                  walk_err_in = wavhv_pkg::WALK_TWO_FMT;
               end else if (chunk_type_ff == wavhv_pkg::TAG_DATA && data_found_ff) begin
                  walk_err_in = wavhv_pkg::WALK_TWO_DATA;
               end else begin
                  if (chunk_type_ff == wavhv_pkg::TAG_FMT) begin
                     fmt_found_in  = 1'b1;
                     fmt_start_in  = ncp_ff + 32'd8;
                     fmt_length_in = ckl;
                  end else if (chunk_type_ff == wavhv_pkg::TAG_DATA) begin
                     data_found_in  = 1'b1;
                     data_start_in  = ncp_ff + 32'd8;
                     data_length_in = ckl;
                  end
                  ncp_in       = ncp_new;
                  wchk         = walk_check(ncp_new, riff_size_ff);
                  walk_done_in = wchk[1];
                  if (wchk[0]) begin
                     walk_err_in = wavhv_pkg::WALK_FAIL;
                  end
               end
            end
         end

         if (fmt_hit) begin
            fmt_fields_in[fmt_diff[3:0]] = b;
         end

         count_in = p + 32'd1;
      end

      snap_in.len         = count_in;
      snap_in.riff_ok     = riff_tag_in == wavhv_pkg::TAG_RIFF;
      snap_in.wave_ok     = wave_tag_in == wavhv_pkg::TAG_WAVE;
      snap_in.riff_size   = riff_size_in;
      snap_in.walk_err    = walk_err_in;
      snap_in.walk_done   = walk_done_in;
      snap_in.fmt_found   = fmt_found_in;
      snap_in.data_found  = data_found_in;
      snap_in.fmt_short   = fmt_length_in < wavhv_pkg::FMT_MIN_LEN;
      snap_in.fmt_tag     = {fmt_fields_in[1], fmt_fields_in[0]};
      snap_in.channels    = {fmt_fields_in[3], fmt_fields_in[2]};
      snap_in.rate        = {fmt_fields_in[7], fmt_fields_in[6],
                             fmt_fields_in[5], fmt_fields_in[4]};
      snap_in.bits        = {fmt_fields_in[15], fmt_fields_in[14]};
      snap_in.data_start  = data_start_in;
      snap_in.data_length = data_length_in;

      // start a fresh file after the last beat
      if (proc_fire && in_last_ff) begin
         count_in       = 32'd0;
         riff_tag_in    = 32'd0;
         riff_size_in   = 32'd0;
         wave_tag_in    = 32'd0;
         ncp_in         = wavhv_pkg::HDR_START;
         chunk_type_in  = 32'd0;
         chunk_size_in  = 32'd0;
         walk_done_in   = 1'b0;
         walk_err_in    = wavhv_pkg::WALK_NONE;
         fmt_found_in   = 1'b0;
         fmt_start_in   = 32'd0;
         fmt_length_in  = 32'd0;
         fmt_fields_in  = '0;
         data_found_in  = 1'b0;
         data_start_in  = 32'd0;
         data_length_in = 32'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= 32'd0;
         riff_tag_ff    <= 32'd0;
         riff_size_ff   <= 32'd0;
         wave_tag_ff    <= 32'd0;
         ncp_ff         <= wavhv_pkg::HDR_START;
         chunk_type_ff  <= 32'd0;
         chunk_size_ff  <= 32'd0;
         walk_done_ff   <= 1'b0;
         walk_err_ff    <= wavhv_pkg::WALK_NONE;
         fmt_found_ff   <= 1'b0;
         fmt_start_ff   <= 32'd0;
         fmt_length_ff  <= 32'd0;
         fmt_fields_ff  <= '0;
         data_found_ff  <= 1'b0;
         data_start_ff  <= 32'd0;
         data_length_ff <= 32'd0;
      end else begin
         count_ff       <= count_in;
         riff_tag_ff    <= riff_tag_in;
         riff_size_ff   <= riff_size_in;
         wave_tag_ff    <= wave_tag_in;
         ncp_ff         <= ncp_in;
         chunk_type_ff  <= chunk_type_in;
         chunk_size_ff  <= chunk_size_in;
         walk_done_ff   <= walk_done_in;
         walk_err_ff    <= walk_err_in;
         fmt_found_ff   <= fmt_found_in;
         fmt_start_ff   <= fmt_start_in;
         fmt_length_ff  <= fmt_length_in;
         fmt_fields_ff  <= fmt_fields_in;
         data_found_ff  <= data_found_in;
         data_start_ff  <= data_start_in;
         data_length_ff <= data_length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_valid_ff <= 1'b0;
      end else if (snap_ready) begin
         snap_valid_ff <= proc_fire && in_last_ff;
      end
      if (snap_ready && proc_fire && in_last_ff) begin
         snap_ff <= snap_in;
      end
   end

   always_comb begin
      logic signed [33:0]    wl_s;
      logic signed [33:0]    len_s;
      logic                  size_bad;
      logic                  rate_ok;
      wavhv_pkg::status_type st;

      wl_s     = $signed({{2{snap_ff.riff_size[31]}}, snap_ff.riff_size});
      len_s    = $signed({2'b00, snap_ff.len});
      size_bad = (wl_s < 34'sd4) || (wl_s + 34'sd8 > len_s);
      rate_ok  = (snap_ff.rate == wavhv_pkg::RATE_48K) ||
                 (snap_ff.rate == wavhv_pkg::RATE_44K);

      if (snap_ff.len[31]) begin
         st = wavhv_pkg::ST_TOO_LONG;
      end else if (snap_ff.len < wavhv_pkg::HDR_START) begin
         st = wavhv_pkg::ST_SHORT;
      end else if (!snap_ff.riff_ok) begin
         st = wavhv_pkg::ST_NOT_RIFF;
      end else if (!snap_ff.wave_ok) begin
         st = wavhv_pkg::ST_NOT_WAVE;
      end else if (size_bad) begin
         st = wavhv_pkg::ST_BAD_SIZE;
      end else if (snap_ff.walk_err == wavhv_pkg::WALK_FAIL || !snap_ff.walk_done) begin
         st = wavhv_pkg::ST_BAD_WALK;
      end else if (snap_ff.walk_err == wavhv_pkg::WALK_TWO_FMT) begin
         st = wavhv_pkg::ST_TWO_FMT;
      end else if (snap_ff.walk_err == wavhv_pkg::WALK_TWO_DATA) begin
         st = wavhv_pkg::ST_TWO_DATA;
      end else if (!snap_ff.fmt_found) begin
         st = wavhv_pkg::ST_NO_FMT;
      end else if (!snap_ff.data_found) begin
         st = wavhv_pkg::ST_NO_DATA;
      end else if (snap_ff.fmt_short) begin
         st = wavhv_pkg::ST_FMT_SHORT;
      end else if (snap_ff.fmt_tag != wavhv_pkg::FMT_PCM) begin
         st = wavhv_pkg::ST_COMPRESSED;
      end else if (snap_ff.bits != wavhv_pkg::BITS_16) begin
         st = wavhv_pkg::ST_NOT_16BIT;
      end else if (snap_ff.channels != wavhv_pkg::MONO) begin
         st = wavhv_pkg::ST_NOT_MONO;
      end else if (!rate_ok) begin
         st = wavhv_pkg::ST_BAD_RATE;
      end else if (snap_ff.data_length[0]) begin
         st = wavhv_pkg::ST_ODD_DATA;
      end else begin
         st = wavhv_pkg::ST_OK;
      end

      rsp_data_in = '0;
      rsp_data_in[4:0] = st;
      if (st == wavhv_pkg::ST_OK) begin
         rsp_data_in[35:5]  = snap_ff.data_start[30:0];
         rsp_data_in[65:36] = snap_ff.data_length[30:1];
         rsp_data_in[81:66] = snap_ff.rate[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= snap_valid_ff;
      end
      if (out_ready && snap_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
